// ===== rtl/framed_zero_crossing_rate_assert.svh =====
// assertion macros shared by the framed zero-crossing rate modules
`ifndef FRAMED_ZERO_CROSSING_RATE_ASSERT_SVH
`define FRAMED_ZERO_CROSSING_RATE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising edge out of reset
`define FZCR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FZCR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define FZCR_ASSERT_IMP(lbl, ante, cons, msg)
`define FZCR_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/fzcr_pkg.sv =====
// shared types and constants of the framed zero-crossing rate block
`default_nettype none

package fzcr_pkg;

    // configuration port
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_SIZE = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOP_SIZE   = 1'b1;

    // register and field widths
    localparam int FRAME_SIZE_BITS = 11;
    localparam int HOP_BITS        = 16;
    localparam int CROSS_BITS      = 10;
    localparam int RATE_BITS       = 17;
    localparam int TOTAL_BITS      = 32;

    localparam logic [FRAME_SIZE_BITS-1:0] FRAME_SIZE_RESET = 11'd256;
    localparam logic [HOP_BITS-1:0]        HOP_SIZE_RESET   = 16'd128;

    // frame queue between front and back
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = 2;
    localparam int QUEUE_CNT_BITS = 3;

    // divider sequencing
    localparam int DIV_STEP_BITS = 5;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HOLD
    } back_state_t;

    typedef struct packed {
        logic [QUEUE_CNT_BITS-1:0] count;
        logic                      not_empty;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== rtl/fzcr_front.sv =====
// front part: sign test, crossing marks, sliding window count and frame-end detection
`default_nettype none

module fzcr_front #(
    parameter int MAX_FRAME   = 1024,
    parameter int SAMPLE_BITS = 16,
    parameter int ADDR_BITS   = 10
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic [fzcr_pkg::FRAME_SIZE_BITS-1:0] frame_size,
    input  wire logic [fzcr_pkg::HOP_BITS-1:0]        hop_size,
    input  wire logic signed [SAMPLE_BITS-1:0]        sample,
    input  wire logic                                 stream_start,
    input  wire logic                                 clear_stats,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire fzcr_pkg::queue_status_t              q_status,
    output logic                                      push,
    output logic [2*ADDR_BITS:0]                      push_data
);
    import fzcr_pkg::*;

    localparam logic [ADDR_BITS-1:0] LAST_ADDR = ADDR_BITS'(MAX_FRAME - 1);
    localparam logic [ADDR_BITS:0]   MAX_WIDE  = (ADDR_BITS + 1)'(MAX_FRAME);

    // stream state
    logic                   started_reg;
    logic                   have_prev_reg;
    logic                   prev_nonneg_reg;
    logic [ADDR_BITS-1:0]   wr_ptr_reg;
    logic [ADDR_BITS-1:0]   fill_reg;
    logic [ADDR_BITS-1:0]   span_reg;
    logic [HOP_BITS-1:0]    until_end_reg;

    // second stage
    logic                   s2_valid_reg;
    logic                   s2_mark_reg;
    logic                   s2_leave_ok_reg;
    logic                   s2_active_reg;
    logic                   s2_start_reg;
    logic                   s2_end_reg;
    logic                   s2_clear_reg;
    logic [ADDR_BITS-1:0]   s2_span_reg;
    logic                   hist_rd_reg;
    logic [ADDR_BITS-1:0]   window_reg;
    logic                   clear_pend_reg;

    // crossing mark history
    logic                   hist_mem [MAX_FRAME];

    logic                   accept;
    logic                   start;
    logic [31:0]            fs_wide;
    logic [31:0]            frame_clamped;
    logic [ADDR_BITS-1:0]   span_new;
    logic [HOP_BITS-1:0]    until_new;
    logic [HOP_BITS-1:0]    hop_m1;
    logic [ADDR_BITS-1:0]   span_eff;
    logic [ADDR_BITS-1:0]   wr_eff;
    logic [ADDR_BITS-1:0]   fill_eff;
    logic [HOP_BITS-1:0]    until_eff;
    logic                   have_prev_eff;
    logic                   nonneg;
    logic                   mark;
    logic [ADDR_BITS:0]     leave_wide;
    logic [ADDR_BITS-1:0]   leave_addr;
    logic                   leave_ok;
    logic                   frame_end;
    logic [ADDR_BITS-1:0]   wr_ptr_next;
    logic [ADDR_BITS-1:0]   fill_next;
    logic [HOP_BITS-1:0]    until_end_next;
    logic [ADDR_BITS-1:0]   window_base;
    logic [ADDR_BITS-1:0]   window_next;
    logic                   clear_pend_next;
    logic [QUEUE_CNT_BITS:0] fill_level;

    // hold off input when the queue might not take the next frame end
    assign fill_level = {1'b0, q_status.count} + (QUEUE_CNT_BITS + 1)'(push);
    assign in_stall   = fill_level >= (QUEUE_CNT_BITS + 1)'(QUEUE_DEPTH);
    assign accept     = in_valid && !in_stall;

    // frame size clamp and hop reload value
    always_comb
    begin
        fs_wide = 32'(frame_size);
        if (fs_wide == 32'd0)
            frame_clamped = 32'd1;
        else if (fs_wide > 32'(MAX_FRAME))
            frame_clamped = 32'(MAX_FRAME);
        else
            frame_clamped = fs_wide;
        span_new  = ADDR_BITS'(frame_clamped - 32'd1);
        until_new = HOP_BITS'(frame_clamped - 32'd1);
        hop_m1    = (hop_size == '0) ? '0 : hop_size - HOP_BITS'(1);
    end

    // effective state for this transfer, with stream restart applied
    assign start         = stream_start || !started_reg;
    assign span_eff      = start ? span_new : span_reg;
    assign wr_eff        = start ? '0 : wr_ptr_reg;
    assign fill_eff      = start ? '0 : fill_reg;
    assign until_eff     = start ? until_new : until_end_reg;
    assign have_prev_eff = start ? 1'b0 : have_prev_reg;

    // crossing mark
    assign nonneg = !sample[SAMPLE_BITS-1];
    assign mark   = have_prev_eff && (nonneg != prev_nonneg_reg);

    // address of the mark that leaves the window
    always_comb
    begin
        if (wr_eff >= span_eff)
            leave_wide = {1'b0, wr_eff} - {1'b0, span_eff};
        else
            leave_wide = {1'b0, wr_eff} + MAX_WIDE - {1'b0, span_eff};
        leave_addr = leave_wide[ADDR_BITS-1:0];
    end

    // leaving entry only counts once it was written in this stream
    assign leave_ok    = (fill_eff == span_eff) && (span_eff != '0);
    assign wr_ptr_next = (wr_eff == LAST_ADDR) ? '0 : wr_eff + ADDR_BITS'(1);
    assign fill_next   = (fill_eff == span_eff) ? fill_eff : fill_eff + ADDR_BITS'(1);

    // frame-end countdown
    assign frame_end      = (until_eff == '0);
    assign until_end_next = frame_end ? hop_m1 : until_eff - HOP_BITS'(1);

    // history memory, one write and one registered read per transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_mem[wr_eff] <= mark;
            hist_rd_reg      <= hist_mem[leave_addr];
        end
    end

    // first stage state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg     <= 1'b0;
            have_prev_reg   <= 1'b0;
            prev_nonneg_reg <= 1'b0;
            wr_ptr_reg      <= '0;
            fill_reg        <= '0;
            span_reg        <= '0;
            until_end_reg   <= '0;
        end
        else if (accept)
        begin
            started_reg     <= 1'b1;
            have_prev_reg   <= 1'b1;
            prev_nonneg_reg <= nonneg;
            wr_ptr_reg      <= wr_ptr_next;
            fill_reg        <= fill_next;
            span_reg        <= span_eff;
            until_end_reg   <= until_end_next;
        end
    end

    // stage two payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_mark_reg     <= mark;
            s2_leave_ok_reg <= leave_ok;
            s2_active_reg   <= (span_eff != '0);
            s2_start_reg    <= start;
            s2_end_reg      <= frame_end;
            s2_clear_reg    <= clear_stats;
            s2_span_reg     <= span_eff;
        end
    end

    // window count update and frame hand-off
    always_comb
    begin
        window_base = s2_start_reg ? '0 : window_reg;
        window_next = window_base
                      + ADDR_BITS'(s2_active_reg && s2_mark_reg)
                      - ADDR_BITS'(s2_leave_ok_reg && hist_rd_reg);
        push        = s2_valid_reg && s2_end_reg;
        push_data   = {window_next, s2_span_reg, clear_pend_reg || s2_clear_reg};
        if (!s2_valid_reg)
            clear_pend_next = clear_pend_reg;
        else if (s2_end_reg)
            clear_pend_next = 1'b0;
        else
            clear_pend_next = clear_pend_reg || s2_clear_reg;
    end

    // stage two control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg   <= 1'b0;
            window_reg     <= '0;
            clear_pend_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg   <= accept;
            clear_pend_reg <= clear_pend_next;
            if (s2_valid_reg)
                window_reg <= window_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fzcr_queue.sv =====
// small frame queue between the front and the divider back part
`default_nettype none

`include "framed_zero_crossing_rate_assert.svh"

module fzcr_queue #(
    parameter int WIDTH = 21
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire logic [WIDTH-1:0]        push_data,
    input  wire logic                    pop,
    output logic [WIDTH-1:0]             head_data,
    output fzcr_pkg::queue_status_t      status
);
    import fzcr_pkg::*;

    logic [WIDTH-1:0]          entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic [QUEUE_CNT_BITS-1:0] count_next;

    assign head_data        = entry_reg[rd_ptr_reg];
    assign status.count     = count_reg;
    assign status.not_empty = (count_reg != '0);

    always_comb
    begin
        count_next = count_reg + QUEUE_CNT_BITS'(push) - QUEUE_CNT_BITS'(pop);
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_BITS'(1);
            count_reg <= count_next;
        end
    end

    // front flow control must keep a slot free for every frame end
    `FZCR_ASSERT_IMP(a_no_overflow, push, (count_reg < QUEUE_CNT_BITS'(QUEUE_DEPTH)), "frame queue overflow")
    `FZCR_ASSERT_IMP(a_no_underflow, pop, (count_reg != '0), "frame queue underflow")

endmodule

`default_nettype wire

// ===== rtl/fzcr_back.sv =====
// back part: running totals, bit-serial rate divider and result register
`default_nettype none

`include "framed_zero_crossing_rate_assert.svh"

module fzcr_back #(
    parameter int ADDR_BITS = 10
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire fzcr_pkg::queue_status_t          q_status,
    input  wire logic [2*ADDR_BITS:0]             q_data,
    output logic                                  pop,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic [fzcr_pkg::CROSS_BITS-1:0]       frame_crossings,
    output logic [fzcr_pkg::RATE_BITS-1:0]        zcr_rate,
    output logic [fzcr_pkg::TOTAL_BITS-1:0]       frame_index,
    output logic [fzcr_pkg::TOTAL_BITS-1:0]       total_crossings,
    output logic [fzcr_pkg::TOTAL_BITS-1:0]       total_frames
);
    import fzcr_pkg::*;

    localparam logic [DIV_STEP_BITS-1:0] LAST_STEP = DIV_STEP_BITS'(RATE_BITS - 1);
    localparam logic [RATE_BITS-1:0]     RATE_ONE  = RATE_BITS'(1) << (RATE_BITS - 1);

    back_state_t            state_reg;
    back_state_t            state_next;
    logic                   load;

    logic [ADDR_BITS-1:0]   cnt_reg;
    logic [ADDR_BITS-1:0]   div_reg;
    logic [ADDR_BITS:0]     rem_reg;
    logic [RATE_BITS-1:0]   quo_reg;
    logic [DIV_STEP_BITS-1:0] step_reg;
    logic [TOTAL_BITS-1:0]  frames_reg;
    logic [TOTAL_BITS-1:0]  crossings_reg;
    logic [TOTAL_BITS-1:0]  index_reg;

    logic                   out_valid_reg;
    logic [CROSS_BITS-1:0]  fc_out_reg;
    logic [RATE_BITS-1:0]   rate_out_reg;
    logic [TOTAL_BITS-1:0]  index_out_reg;
    logic [TOTAL_BITS-1:0]  cross_out_reg;
    logic [TOTAL_BITS-1:0]  frames_out_reg;

    logic [ADDR_BITS-1:0]   q_cnt;
    logic [ADDR_BITS-1:0]   q_div;
    logic                   q_clear;
    logic [TOTAL_BITS-1:0]  frames_base;
    logic [TOTAL_BITS-1:0]  crossings_base;
    logic [TOTAL_BITS:0]    frames_sum;
    logic [TOTAL_BITS:0]    crossings_sum;
    logic                   rem_ge;
    logic [ADDR_BITS:0]     rem_diff;
    logic [TOTAL_BITS-1:0]  cnt_wide;

    // queue entry fields
    assign q_cnt   = q_data[2*ADDR_BITS:ADDR_BITS+1];
    assign q_div   = q_data[ADDR_BITS:1];
    assign q_clear = q_data[0];

    // saturating totals for the frame being taken
    always_comb
    begin
        frames_base    = q_clear ? '0 : frames_reg;
        crossings_base = q_clear ? '0 : crossings_reg;
        frames_sum     = {1'b0, frames_base} + (TOTAL_BITS + 1)'(1);
        crossings_sum  = {1'b0, crossings_base} + (TOTAL_BITS + 1)'(q_cnt);
    end

    // one quotient bit per step
    assign rem_ge   = rem_reg >= {1'b0, div_reg};
    assign rem_diff = rem_ge ? rem_reg - {1'b0, div_reg} : rem_reg;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_status.not_empty)
                begin
                    pop        = 1'b1;
                    state_next = (q_div == '0) ? BK_HOLD : BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (step_reg == LAST_STEP)
                    state_next = BK_HOLD;
            end
            BK_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load       = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    // totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_reg    <= '0;
            crossings_reg <= '0;
        end
        else if (pop)
        begin
            frames_reg    <= frames_sum[TOTAL_BITS] ? '1 : frames_sum[TOTAL_BITS-1:0];
            crossings_reg <= crossings_sum[TOTAL_BITS] ? '1
                                                       : crossings_sum[TOTAL_BITS-1:0];
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cnt_reg   <= q_cnt;
            div_reg   <= q_div;
            rem_reg   <= {1'b0, q_cnt};
            quo_reg   <= '0;
            step_reg  <= '0;
            index_reg <= frames_base;
        end
        else if (state_reg == BK_DIV)
        begin
            rem_reg  <= {rem_diff[ADDR_BITS-1:0], 1'b0};
            quo_reg  <= {quo_reg[RATE_BITS-2:0], rem_ge};
            step_reg <= step_reg + DIV_STEP_BITS'(1);
        end
    end

    // result register
    assign cnt_wide = TOTAL_BITS'(cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= load || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fc_out_reg     <= (cnt_wide > TOTAL_BITS'((1 << CROSS_BITS) - 1))
                              ? '1 : cnt_wide[CROSS_BITS-1:0];
            rate_out_reg   <= quo_reg;
            index_out_reg  <= index_reg;
            cross_out_reg  <= crossings_reg;
            frames_out_reg <= frames_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign frame_crossings = fc_out_reg;
    assign zcr_rate        = rate_out_reg;
    assign frame_index     = index_out_reg;
    assign total_crossings = cross_out_reg;
    assign total_frames    = frames_out_reg;

    `FZCR_ASSERT_IMP(a_div_nonzero, (state_reg == BK_DIV), (div_reg != '0), "divide by zero in rate divider")
    `FZCR_ASSERT_IMP(a_rate_bound, (state_reg == BK_HOLD), (quo_reg <= RATE_ONE), "rate above one")
    `FZCR_ASSERT_NXT(a_index_follows, load, ((frames_out_reg == '1) || (frames_out_reg == index_out_reg + TOTAL_BITS'(1))), "frame index out of step with frame total")

endmodule

`default_nettype wire

// ===== rtl/framed_zero_crossing_rate.sv =====
// Framed zero-crossing rate: takes one sample per cycle while in_stall is low; a frame
// end yields its result through front stage two, the frame queue and the divider.
// The back part does one frame at a time: take, 17 divider steps (none for size 1), load;
// a 4-entry frame queue absorbs bursts, and input stalls only when frame ends come faster.
// rst_n is asynchronous, active low: control state clears at once, registers take
// their reset values; the mark history is not swept, a fill count masks unwritten entries.
`default_nettype none

module framed_zero_crossing_rate #(
    parameter int MAX_FRAME   = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [fzcr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [fzcr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [SAMPLE_BITS-1:0]       sample,
    input  wire logic                                stream_start,
    input  wire logic                                clear_stats,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [fzcr_pkg::CROSS_BITS-1:0]          frame_crossings,
    output logic [fzcr_pkg::RATE_BITS-1:0]           zcr_rate,
    output logic [fzcr_pkg::TOTAL_BITS-1:0]          frame_index,
    output logic [fzcr_pkg::TOTAL_BITS-1:0]          total_crossings,
    output logic [fzcr_pkg::TOTAL_BITS-1:0]          total_frames
);
    import fzcr_pkg::*;

    localparam int ADDR_BITS = $clog2(MAX_FRAME);
    localparam int ITEM_BITS = 2 * ADDR_BITS + 1;

    logic [FRAME_SIZE_BITS-1:0] frame_size_reg;
    logic [HOP_BITS-1:0]        hop_size_reg;

    logic                       push;
    logic [ITEM_BITS-1:0]       push_data;
    logic                       pop;
    logic [ITEM_BITS-1:0]       head_data;
    queue_status_t              q_status;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_size_reg <= FRAME_SIZE_RESET;
            hop_size_reg   <= HOP_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FRAME_SIZE: frame_size_reg <= cfg_data[FRAME_SIZE_BITS-1:0];
                CFG_HOP_SIZE:   hop_size_reg   <= cfg_data[HOP_BITS-1:0];
                default:        hop_size_reg   <= hop_size_reg;
            endcase
        end
    end

    // sample side
    fzcr_front #(
        .MAX_FRAME   (MAX_FRAME),
        .SAMPLE_BITS (SAMPLE_BITS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_size   (frame_size_reg),
        .hop_size     (hop_size_reg),
        .sample       (sample),
        .stream_start (stream_start),
        .clear_stats  (clear_stats),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .q_status     (q_status),
        .push         (push),
        .push_data    (push_data)
    );

    // frame queue
    fzcr_queue #(
        .WIDTH (ITEM_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .status    (q_status)
    );

    // result side
    fzcr_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_status        (q_status),
        .q_data          (head_data),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .frame_crossings (frame_crossings),
        .zcr_rate        (zcr_rate),
        .frame_index     (frame_index),
        .total_crossings (total_crossings),
        .total_frames    (total_frames)
    );

endmodule

`default_nettype wire
